[src/sbe_pkg.sv]
// Shared types, constants and helpers for the S/PDIF subframe encoder.
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CELLS_W = 64;
  localparam int HALF_W = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int FRAMES_PER_BLOCK_DEF = 192;

  localparam logic [31:0] CSW_RESET = 32'd4;
  localparam logic VALIDITY_RESET = 1'b1;

  localparam logic REG_CSW = 1'b0;
  localparam logic REG_VALIDITY = 1'b1;

  localparam logic [7:0] PRE_X_LOW = 8'b11100010;
  localparam logic [7:0] PRE_X_HIGH = 8'b00011101;
  localparam logic [7:0] PRE_Y_LOW = 8'b11100100;
  localparam logic [7:0] PRE_Y_HIGH = 8'b00011011;
  localparam logic [7:0] PRE_Z_LOW = 8'b11101000;
  localparam logic [7:0] PRE_Z_HIGH = 8'b00010111;

  typedef struct packed {
    logic line_level;
    logic channel_is_b;
    logic frame_zero;
    logic cs_bit;
    logic validity;
  } sbe_ctrl_t;

  typedef struct packed {
    logic [CELLS_W-1:0] cells;
    logic end_level;
  } sbe_code_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/sbe_intf.sv]
// Valid/ready channel interfaces for samples in and coded subframes out.
`timescale 1ns / 1ps
`default_nettype none

interface sbe_sample_if import sbe_pkg::*; ();
  logic valid;
  logic ready;
  logic [SAMPLE_W-1:0] pcm_sample;

  modport source (output valid, output pcm_sample, input ready);
  modport sink (input valid, input pcm_sample, output ready);
endinterface

interface sbe_cells_if import sbe_pkg::*; ();
  logic valid;
  logic ready;
  logic [HALF_W-1:0] cells_low;
  logic [HALF_W-1:0] cells_high;

  modport source (output valid, output cells_low, output cells_high, input ready);
  modport sink (input valid, input cells_low, input cells_high, output ready);
endinterface

`default_nettype wire

[src/sbe_bmc.sv]
// Subframe assembly, parity, preamble select and biphase-mark coding.
`timescale 1ns / 1ps
`default_nettype none

module sbe_bmc import sbe_pkg::*; (
  input  logic [SAMPLE_W-1:0] pcm_sample,
  input  sbe_ctrl_t           ctrl,
  output sbe_code_t           code
);

  logic [31:0] word;
  logic [27:0] flip;
  logic [7:0]  pre;
  logic        parity;

  assign parity = (^pcm_sample) ^ ctrl.validity ^ ctrl.cs_bit;
  assign word = {parity, ctrl.cs_bit, 1'b0, ctrl.validity, 4'b0000, pcm_sample, 8'h00};
  assign flip = ~word[31:4];

  always_comb begin
    if (ctrl.channel_is_b) begin
      pre = ctrl.line_level ? PRE_Y_HIGH : PRE_Y_LOW;
    end else if (ctrl.frame_zero) begin
      pre = ctrl.line_level ? PRE_Z_HIGH : PRE_Z_LOW;
    end else begin
      pre = ctrl.line_level ? PRE_X_HIGH : PRE_X_LOW;
    end
  end

  always_comb begin
    logic lv;
    code.cells[7:0] = rev8(pre);
    for (int i = 0; i < 28; i++) begin
      lv = ctrl.line_level ^ (^(flip & ((28'd1 << i) - 28'd1)));
      code.cells[8+2*i] = ~lv;
      code.cells[9+2*i] = ~lv ^ word[4+i];
    end
    code.end_level = ctrl.line_level ^ (^flip);
  end

endmodule

`default_nettype wire

[src/spdif_subframe_bmc_encoder_top.sv]
// Top level: config registers, frame/channel state, encoder and output skid buffer.
// A word accepted is registered in out_cells, or in skid_cells while coded is stalled, and offered on coded.
// One word per cycle while coded is not stalled; the encode from sample into out_cells is combinational.
// A two-entry output buffer lets one more word enter while a result is stalled.
// Reset (rst, synchronous): channel A, frame 0, line level low, buffers empty,
// channel_status_word = 4, validity_flag = 1.
`timescale 1ns / 1ps
`default_nettype none

module spdif_subframe_bmc_encoder_top import sbe_pkg::*; #(
  parameter int FRAMES_PER_BLOCK = FRAMES_PER_BLOCK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  sbe_sample_if.sink        sample,
  sbe_cells_if.source       coded
);

  localparam int FW = $clog2(FRAMES_PER_BLOCK);

  logic [31:0]       channel_status_word;
  logic              validity_flag;
  logic              line_level;
  logic              channel_is_b;
  logic [FW-1:0]     frame_index;
  logic [FW-1:0]     frame_index_next;
  logic              out_valid;
  logic [CELLS_W-1:0] out_cells;
  logic              skid_valid;
  logic [CELLS_W-1:0] skid_cells;

  logic       accept;
  logic       out_fire;
  logic       load_out;
  logic       load_skid;
  logic       cfg_write;
  logic       reg_sel;
  logic [8:0] frame_ext;
  sbe_ctrl_t  ctrl;
  sbe_code_t  code;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_sel = paddr[ADDR_W-1];

  always_comb begin
    unique case (reg_sel)
      REG_CSW:      prdata = channel_status_word;
      REG_VALIDITY: prdata = {{(DATA_W-1){1'b0}}, validity_flag};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_status_word <= CSW_RESET;
      validity_flag <= VALIDITY_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CSW:      channel_status_word <= pwdata;
        REG_VALIDITY: validity_flag <= pwdata[0];
        default:      ;
      endcase
    end
  end

  assign frame_ext = 9'(frame_index);
  assign ctrl.line_level = line_level;
  assign ctrl.channel_is_b = channel_is_b;
  assign ctrl.frame_zero = (frame_index == '0);
  assign ctrl.cs_bit = (frame_ext < 9'd32) ? channel_status_word[frame_ext[4:0]] : 1'b0;
  assign ctrl.validity = validity_flag;

  sbe_bmc u_bmc (
    .pcm_sample (sample.pcm_sample),
    .ctrl       (ctrl),
    .code       (code)
  );

  assign sample.ready = ~skid_valid;
  assign accept = sample.valid & sample.ready;
  assign out_fire = out_valid & coded.ready;
  assign load_out = (out_fire | ~out_valid) & ~skid_valid & accept;
  assign load_skid = out_valid & ~coded.ready & accept;

  assign frame_index_next = (frame_index == FW'(FRAMES_PER_BLOCK - 1)) ? '0
                                                                       : frame_index + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_level <= 1'b0;
      channel_is_b <= 1'b0;
      frame_index <= '0;
    end else if (accept) begin
      line_level <= code.end_level;
      channel_is_b <= ~channel_is_b;
      if (channel_is_b) begin
        frame_index <= frame_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire | ~out_valid) begin
      out_valid <= skid_valid | accept;
      skid_valid <= 1'b0;
    end else if (load_skid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((out_fire | ~out_valid) & skid_valid) begin
      out_cells <= skid_cells;
    end else if (load_out) begin
      out_cells <= code.cells;
    end
    if (load_skid) begin
      skid_cells <= code.cells;
    end
  end

  assign coded.valid = out_valid;
  assign coded.cells_low = out_cells[HALF_W-1:0];
  assign coded.cells_high = out_cells[CELLS_W-1:HALF_W];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && !out_valid) |=> (out_valid && !skid_valid))
    else $error("accepted word not moved to the output register");

  a_channel_toggles: assert property (@(posedge clk) disable iff (rst)
    accept |=> (channel_is_b != $past(channel_is_b)))
    else $error("channel did not alternate");

  a_frame_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(frame_index) < FRAMES_PER_BLOCK)
    else $error("frame index out of range");

  a_frame_steady_on_a: assert property (@(posedge clk) disable iff (rst)
    (accept && !channel_is_b) |=> $stable(frame_index))
    else $error("frame index moved after channel A");

endmodule

`default_nettype wire

[tb/spdif_subframe_bmc_encoder_top_tb.sv]
// Testbench for the S/PDIF subframe encoder: predicts each biphase-mark word and checks it.
`timescale 1ns / 1ps

class subframe_coder_check;
  typedef struct packed {
    logic [31:0] high;
    logic [31:0] low;
  } coded_cells_t;

  logic [31:0]  status_word;
  logic         validity;
  logic         line_level;
  logic [7:0]   frame_index;
  logic         channel_is_b;
  coded_cells_t pending_cells[$];
  int           errors;

  function new();
    status_word = sbe_pkg::CSW_RESET;
    validity = sbe_pkg::VALIDITY_RESET;
    line_level = 1'b0;
    frame_index = 8'd0;
    channel_is_b = 1'b0;
    errors = 0;
  endfunction

  function void write_reg(logic index, logic [31:0] value);
    if (index == sbe_pkg::REG_CSW) begin
      status_word = value;
    end else begin
      validity = value[0];
    end
  endfunction

  function int pending();
    return pending_cells.size();
  endfunction

  function void note_sample(logic [15:0] pcm);
    logic [31:0]  word;
    logic [7:0]   pre;
    logic [63:0]  cells;
    logic         lvl;
    logic [8:0]   next_frame;
    coded_cells_t result;
    word = 32'd0;
    word[23:8] = pcm;
    word[28] = validity;
    word[30] = (frame_index < 8'd32) ? status_word[frame_index[4:0]] : 1'b0;
    word[31] = ^word[30:4];
    lvl = line_level;
    if (channel_is_b) begin
      pre = lvl ? sbe_pkg::PRE_Y_HIGH : sbe_pkg::PRE_Y_LOW;
    end else if (frame_index == 8'd0) begin
      pre = lvl ? sbe_pkg::PRE_Z_HIGH : sbe_pkg::PRE_Z_LOW;
    end else begin
      pre = lvl ? sbe_pkg::PRE_X_HIGH : sbe_pkg::PRE_X_LOW;
    end
    cells = 64'd0;
    // send the preamble most significant bit first
    for (int i = 0; i < 8; i++) begin
      cells[i] = pre[7-i];
    end
    for (int t = 4; t < 32; t++) begin
      lvl = ~lvl;
      cells[2*t] = lvl;
      if (word[t]) begin
        lvl = ~lvl;
      end
      cells[2*t+1] = lvl;
    end
    line_level = lvl;
    if (channel_is_b) begin
      next_frame = {1'b0, frame_index} + 9'd1;
      frame_index = (next_frame >= sbe_pkg::FRAMES_PER_BLOCK_DEF) ? 8'd0 : next_frame[7:0];
      channel_is_b = 1'b0;
    end else begin
      channel_is_b = 1'b1;
    end
    result.low = cells[31:0];
    result.high = cells[63:32];
    pending_cells.push_back(result);
  endfunction

  function void check_cells(logic [31:0] low, logic [31:0] high);
    coded_cells_t want;
    if (pending_cells.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected word: cells_high=%h cells_low=%h", high, low);
      end
      return;
    end
    want = pending_cells.pop_front();
    if (low !== want.low) begin
      errors++;
      if (errors <= 10) begin
        $display("cells_low mismatch: expected %h, got %h", want.low, low);
      end
    end
    if (high !== want.high) begin
      errors++;
      if (errors <= 10) begin
        $display("cells_high mismatch: expected %h, got %h", want.high, high);
      end
    end
  endfunction
endclass

module spdif_subframe_bmc_encoder_top_tb;
  import sbe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 342;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                stall_cycles;
  subframe_coder_check sb;

  sbe_sample_if sample ();
  sbe_cells_if  coded ();

  spdif_subframe_bmc_encoder_top uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample(sample),
    .coded(coded)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    coded.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample.valid && sample.ready) begin
        sb.note_sample(sample.pcm_sample);
      end
      if (coded.valid && coded.ready) begin
        sb.check_cells(coded.cells_low, coded.cells_high);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample.valid && sample.ready) || (coded.valid && coded.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_sample(input logic [15:0] pcm);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.pcm_sample <= pcm;
    do @(posedge clk); while (!sample.ready);
  endtask

  // hold the sender until every word has come out
  task automatic drain();
    sample.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({index, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(index, value);
  endtask

  task automatic run_phase(input int words, input int tx_pct, input int rx_pct);
    logic [15:0] pcm;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < words; i++) begin
      case ($urandom_range(9))
        0: pcm = 16'h0000;
        1: pcm = 16'hFFFF;
        default: pcm = 16'($urandom);
      endcase
      send_sample(pcm);
      if (i == words / 2) begin
        drain();
      end
    end
    drain();
  endtask

  initial begin
    logic [15:0] directed[$];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample.valid = 1'b0;
    sample.pcm_sample = '0;
    coded.ready = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    sb = new();
    directed = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h5555, 16'hAAAA,
                 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234, 16'hFEDC,
                 16'h7FFF, 16'hFFFE, 16'h0003, 16'hC000, 16'h0000, 16'h0000,
                 16'hFFFF, 16'hFFFF, 16'h8001, 16'h4002, 16'h2004, 16'h1008};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_sample(directed[i]);
    end
    drain();

    write_reg(REG_CSW, 32'hFFFF_FFFF);
    write_reg(REG_VALIDITY, 32'hFFFF_FFFE);
    run_phase(PHASE_WORDS, 24, 57);

    write_reg(REG_CSW, 32'h0000_0000);
    write_reg(REG_VALIDITY, 32'hFFFF_FFFF);
    run_phase(PHASE_WORDS, 57, 24);

    write_reg(REG_CSW, $urandom);
    write_reg(REG_VALIDITY, $urandom);
    run_phase(PHASE_WORDS, 0, 0);

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
